// ===== rtl/fat_boot_sector_checker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// fat_boot_sector_checker_unit_defines.svh
// assertion macros shared by the boot sector checker's checker module
// ----------------------------------------------------------------------------
`ifndef FAT_BOOT_SECTOR_CHECKER_UNIT_DEFINES_SVH
`define FAT_BOOT_SECTOR_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FBSC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbsc assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define FBSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbsc assertion failed");

`endif

// ===== rtl/fbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbsc_pkg
// types, offsets, limits and geometry tables of the boot sector checker
// ----------------------------------------------------------------------------
package fbsc_pkg;

	localparam int SectorBytes   = 512;
	localparam int OffsetW       = $clog2(SectorBytes + 1);
	localparam int GeomKnown     = 8;
	localparam int GeomCount     = 8;
	localparam int GeomLimit     = (GeomCount < GeomKnown) ? GeomCount : GeomKnown;

	// byte offsets of the captured fields
	localparam int OffJump0      = 0;
	localparam int OffJump2      = 2;
	localparam int OffBpsLo      = 11;
	localparam int OffBpsHi      = 12;
	localparam int OffSpc        = 13;
	localparam int OffRsvdLo     = 14;
	localparam int OffRsvdHi     = 15;
	localparam int OffFats       = 16;
	localparam int OffRootLo     = 17;
	localparam int OffRootHi     = 18;
	localparam int OffTot16Lo    = 19;
	localparam int OffTot16Hi    = 20;
	localparam int OffMedia      = 21;
	localparam int OffFatSzLo    = 22;
	localparam int OffFatSzHi    = 23;
	localparam int OffTot32B0    = 32;
	localparam int OffTot32B1    = 33;
	localparam int OffTot32B2    = 34;
	localparam int OffTot32B3    = 35;
	localparam int OffExtMark    = 38;
	localparam int OffSigLo      = 510;
	localparam int OffSigHi      = 511;

	// check values
	localparam logic [7:0]  SigLo        = 8'h55;
	localparam logic [7:0]  SigHi        = 8'hAA;
	localparam logic [7:0]  JmpShort     = 8'hEB;
	localparam logic [7:0]  JmpNop       = 8'h90;
	localparam logic [7:0]  JmpNear      = 8'hE9;
	localparam logic [7:0]  MediaMin     = 8'hF0;
	localparam logic [7:0]  ExtMarkA     = 8'h29;
	localparam logic [7:0]  ExtMarkB     = 8'h28;
	localparam logic [7:0]  MaxFats      = 8'd4;
	localparam logic [15:0] MaxSecSize   = 16'd4096;
	localparam logic [31:0] SmallVolume  = 32'd10000;
	localparam logic [31:0] Fat12Limit   = 32'd4085;
	localparam logic [31:0] Fat16Limit   = 32'd65525;
	localparam int          DirEntryLog  = 5;  // 32 bytes per directory entry

	localparam logic [12:0] GeomTotal [GeomKnown] = '{
		13'd320, 13'd360, 13'd640, 13'd720, 13'd1440, 13'd2400, 13'd2880, 13'd5760
	};
	localparam logic [7:0] GeomMedia [GeomKnown] = '{
		8'hFE, 8'hFC, 8'hFF, 8'hFD, 8'hF9, 8'hF9, 8'hF0, 8'hF0
	};

	typedef enum logic [1:0] {
		FatNone = 2'd0,
		Fat12   = 2'd1,
		Fat16   = 2'd2,
		Fat32   = 2'd3
	} fat_kind_t;

	typedef struct packed {
		logic [7:0]  jump0;
		logic [7:0]  jump2;
		logic [15:0] bps;
		logic [7:0]  spc;
		logic [15:0] rsvd;
		logic [7:0]  fats;
		logic [15:0] root;
		logic [15:0] tot16;
		logic [7:0]  media;
		logic [15:0] fatsz;
		logic [31:0] tot32;
		logic [7:0]  ext;
		logic [15:0] sig;
	} bpb_fields_t;

	typedef struct packed {
		logic        short_buf;
		bpb_fields_t fields;
	} snap_t;

	typedef struct packed {
		logic        short_buf;
		logic        valid;
		logic        sig_ok;
		logic        jmp_ok;
		logic        bpb_ok;
		logic        ext;
		logic [31:0] total;
		logic [20:0] rootsec;
		logic [19:0] part;      // reserved plus FAT area
		logic [2:0]  spc_log;
		logic [3:0]  geo;
	} mid_t;

	typedef struct packed {
		logic        status;
		logic        overall_valid;
		logic        signature_ok;
		logic        jump_ok;
		logic        bpb_ok;
		logic        extended_bpb;
		fat_kind_t   fat_kind;
		logic [31:0] sector_total;
		logic [20:0] root_dir_sector_count;
		logic [21:0] data_start_sector;
		logic [31:0] cluster_total;
		logic [3:0]  geometry_match;
	} res_t;

	// bit index of a one-hot value
	function automatic logic [3:0] log2_onehot(input logic [15:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				r = r | 4'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/fbsc_capture.sv =====
// ----------------------------------------------------------------------------
// fbsc_capture
// byte offset counter and field capture; snapshots the fields on the last beat
// ----------------------------------------------------------------------------
module fbsc_capture (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     sector_byte,
	input  logic           end_of_buffer,
	output logic           snap_valid_s1,
	output fbsc_pkg::snap_t snap_s1,
	input  logic           snap_ready
);
	import fbsc_pkg::*;

	logic [OffsetW-1:0] offset_q;
	bpb_fields_t        fld_q;
	bpb_fields_t        fld_d;
	logic               beat;

	assign in_ready = !snap_valid_s1 || snap_ready;
	assign beat     = in_valid && in_ready;

	always_comb begin
		fld_d = fld_q;
		case (offset_q)
			OffsetW'(OffJump0):   fld_d.jump0        = sector_byte;
			OffsetW'(OffJump2):   fld_d.jump2        = sector_byte;
			OffsetW'(OffBpsLo):   fld_d.bps[7:0]     = sector_byte;
			OffsetW'(OffBpsHi):   fld_d.bps[15:8]    = sector_byte;
			OffsetW'(OffSpc):     fld_d.spc          = sector_byte;
			OffsetW'(OffRsvdLo):  fld_d.rsvd[7:0]    = sector_byte;
			OffsetW'(OffRsvdHi):  fld_d.rsvd[15:8]   = sector_byte;
			OffsetW'(OffFats):    fld_d.fats         = sector_byte;
			OffsetW'(OffRootLo):  fld_d.root[7:0]    = sector_byte;
			OffsetW'(OffRootHi):  fld_d.root[15:8]   = sector_byte;
			OffsetW'(OffTot16Lo): fld_d.tot16[7:0]   = sector_byte;
			OffsetW'(OffTot16Hi): fld_d.tot16[15:8]  = sector_byte;
			OffsetW'(OffMedia):   fld_d.media        = sector_byte;
			OffsetW'(OffFatSzLo): fld_d.fatsz[7:0]   = sector_byte;
			OffsetW'(OffFatSzHi): fld_d.fatsz[15:8]  = sector_byte;
			OffsetW'(OffTot32B0): fld_d.tot32[7:0]   = sector_byte;
			OffsetW'(OffTot32B1): fld_d.tot32[15:8]  = sector_byte;
			OffsetW'(OffTot32B2): fld_d.tot32[23:16] = sector_byte;
			OffsetW'(OffTot32B3): fld_d.tot32[31:24] = sector_byte;
			OffsetW'(OffExtMark): fld_d.ext          = sector_byte;
			OffsetW'(OffSigLo):   fld_d.sig[7:0]     = sector_byte;
			OffsetW'(OffSigHi):   fld_d.sig[15:8]    = sector_byte;
			default: ;
		endcase
	end

	// offset saturates once the whole sector is in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (beat) begin
			if (end_of_buffer) begin
				offset_q <= '0;
			end else if (offset_q != OffsetW'(SectorBytes)) begin
				offset_q <= offset_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			fld_q <= fld_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (beat && end_of_buffer) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat && end_of_buffer) begin
			snap_s1.fields    <= fld_d;
			snap_s1.short_buf <= offset_q < OffsetW'(SectorBytes - 1);
		end
	end

endmodule

// ===== rtl/fbsc_check.sv =====
// ----------------------------------------------------------------------------
// fbsc_check
// field sanity checks, root directory size, FAT area and geometry lookup
// ----------------------------------------------------------------------------
module fbsc_check (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            snap_valid_s1,
	input  fbsc_pkg::snap_t snap_s1,
	output logic            snap_ready,
	output logic            mid_valid_s2,
	output fbsc_pkg::mid_t  mid_s2,
	input  logic            mid_ready
);
	import fbsc_pkg::*;

	bpb_fields_t f;
	mid_t        m;
	logic        bps_ok;
	logic        spc_ok;
	logic        fats_ok;
	logic        media_ok;
	logic [15:0] bps_m1;
	logic [3:0]  bps_log;
	logic [21:0] root_sum;
	logic [18:0] fat_area;
	logic        ex_hit;
	logic        tot_hit;
	logic [3:0]  ex_idx;
	logic [3:0]  tot_idx;

	assign f          = snap_s1.fields;
	assign snap_ready = !mid_valid_s2 || mid_ready;
	assign bps_m1     = f.bps - 16'd1;
	assign bps_log    = log2_onehot(f.bps);

	always_comb begin
		bps_ok   = (f.bps != '0) && ((f.bps & bps_m1) == '0) && (f.bps <= MaxSecSize);
		spc_ok   = (f.spc != '0) && ((f.spc & (f.spc - 8'd1)) == '0);
		fats_ok  = (f.fats != '0) && (f.fats <= MaxFats);
		media_ok = f.media >= MediaMin;

		// round up to whole sectors, then shift by the sector size
		root_sum = {1'b0, f.root, {DirEntryLog{1'b0}}} + {10'b0, bps_m1[11:0]};
		fat_area = 19'(f.fats[2:0]) * 19'(f.fatsz);

		// first exact match wins, then the first total-only match
		ex_hit  = 1'b0;
		tot_hit = 1'b0;
		ex_idx  = '0;
		tot_idx = '0;
		for (int i = GeomLimit - 1; i >= 0; i--) begin
			if (f.tot16 != '0 ? ({3'b0, GeomTotal[i]} == f.tot16)
			                  : ({19'b0, GeomTotal[i]} == f.tot32)) begin
				tot_hit = 1'b1;
				tot_idx = 4'(i);
				if (GeomMedia[i] == f.media) begin
					ex_hit = 1'b1;
					ex_idx = 4'(i);
				end
			end
		end

		m.short_buf = snap_s1.short_buf;
		m.sig_ok    = (f.sig[7:0] == SigLo) && (f.sig[15:8] == SigHi);
		m.jmp_ok    = ((f.jump0 == JmpShort) && (f.jump2 == JmpNop)) || (f.jump0 == JmpNear);
		m.bpb_ok    = bps_ok && spc_ok && fats_ok && media_ok;
		m.ext       = (f.ext == ExtMarkA) || (f.ext == ExtMarkB);
		m.total     = (f.tot16 != '0) ? {16'b0, f.tot16} : f.tot32;
		m.rootsec   = 21'(root_sum >> bps_log);
		m.part      = {4'b0, f.rsvd} + {1'b0, fat_area};
		m.spc_log   = 3'(log2_onehot({8'b0, f.spc}));
		m.geo       = ex_hit ? ex_idx : (tot_hit ? tot_idx : 4'(GeomLimit));
		m.valid     = m.sig_ok && m.bpb_ok && (m.jmp_ok || (m.total < SmallVolume));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_valid_s2 <= 1'b0;
		end else if (snap_ready) begin
			mid_valid_s2 <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid_s1) begin
			mid_s2 <= m;
		end
	end

endmodule

// ===== rtl/fbsc_derive.sv =====
// ----------------------------------------------------------------------------
// fbsc_derive
// first data sector, cluster count and FAT kind into the result register
// ----------------------------------------------------------------------------
module fbsc_derive (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mid_valid_s2,
	input  fbsc_pkg::mid_t mid_s2,
	output logic           mid_ready,
	output logic           res_valid_q,
	output fbsc_pkg::res_t res_q,
	input  logic           res_ready
);
	import fbsc_pkg::*;

	res_t        r;
	logic [21:0] first;
	logic [31:0] first_ext;
	logic [31:0] data;
	logic [31:0] clusters;

	assign mid_ready = !res_valid_q || res_ready;

	always_comb begin
		first     = {2'b0, mid_s2.part} + {1'b0, mid_s2.rootsec};
		first_ext = {10'b0, first};
		data      = (mid_s2.total > first_ext) ? (mid_s2.total - first_ext) : '0;
		clusters  = data >> mid_s2.spc_log;

		r = '0;
		if (mid_s2.short_buf) begin
			r.status = 1'b1;
		end else begin
			r.overall_valid  = mid_s2.valid;
			r.signature_ok   = mid_s2.sig_ok;
			r.jump_ok        = mid_s2.jmp_ok;
			r.bpb_ok         = mid_s2.bpb_ok;
			r.extended_bpb   = mid_s2.ext;
			r.sector_total   = mid_s2.total;
			r.geometry_match = mid_s2.geo;
			if (mid_s2.bpb_ok) begin
				r.root_dir_sector_count = mid_s2.rootsec;
				r.data_start_sector     = first;
				r.cluster_total         = clusters;
				if (clusters < Fat12Limit) begin
					r.fat_kind = Fat12;
				end else if (clusters < Fat16Limit) begin
					r.fat_kind = Fat16;
				end else begin
					r.fat_kind = Fat32;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (mid_ready) begin
			res_valid_q <= mid_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_ready && mid_valid_s2) begin
			res_q <= r;
		end
	end

endmodule

// ===== rtl/fat_boot_sector_checker_unit.sv =====
// ----------------------------------------------------------------------------
// fat_boot_sector_checker_unit
// streaming FAT boot sector parser and checker, one byte per beat
// ----------------------------------------------------------------------------
// Feed the boot sector one byte per beat from offset zero and flag the final
// byte with end_of_buffer. The block takes a byte every cycle; it only holds
// off in_ready when the snapshot, check and result stages all hold a buffer
// and out_ready is low. One result beat comes out for each buffer, after its
// final byte is taken, through a snapshot stage, a check stage and the result
// register. Buffers shorter than 512 bytes report status 1 with every other
// field zero; bytes past 511 are ignored. The next byte after the final one
// starts a new buffer. When the BPB fails its checks, fat kind, root directory
// sectors, first data sector and cluster count read zero, while the sector
// total and the geometry index are still reported.
module fat_boot_sector_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  sector_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic        overall_valid,
	output logic        signature_ok,
	output logic        jump_ok,
	output logic        bpb_ok,
	output logic        extended_bpb,
	output logic [1:0]  fat_kind,
	output logic [31:0] sector_total,
	output logic [20:0] root_dir_sector_count,
	output logic [21:0] data_start_sector,
	output logic [31:0] cluster_total,
	output logic [3:0]  geometry_match
);
	import fbsc_pkg::*;

	// snapshot of the captured fields, taken on the final byte
	logic  snap_valid_s1;
	snap_t snap_s1;
	logic  snap_ready;

	// checked fields and partial sums
	logic  mid_valid_s2;
	mid_t  mid_s2;
	logic  mid_ready;

	// result register
	res_t  res_q;

	// offset counter and field capture; the field registers are free for the
	// next buffer as soon as the snapshot is taken
	fbsc_capture u_capture (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sector_byte   (sector_byte),
		.end_of_buffer (end_of_buffer),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.snap_ready    (snap_ready)
	);

	// sanity checks, root directory sectors, FAT area, geometry lookup
	fbsc_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.snap_ready    (snap_ready),
		.mid_valid_s2  (mid_valid_s2),
		.mid_s2        (mid_s2),
		.mid_ready     (mid_ready)
	);

	// first data sector, cluster count and FAT kind; holds the result beat
	fbsc_derive u_derive (
		.clk          (clk),
		.arst_n       (arst_n),
		.mid_valid_s2 (mid_valid_s2),
		.mid_s2       (mid_s2),
		.mid_ready    (mid_ready),
		.res_valid_q  (out_valid),
		.res_q        (res_q),
		.res_ready    (out_ready)
	);

	// result beat fields
	assign status                = res_q.status;
	assign overall_valid         = res_q.overall_valid;
	assign signature_ok          = res_q.signature_ok;
	assign jump_ok               = res_q.jump_ok;
	assign bpb_ok                = res_q.bpb_ok;
	assign extended_bpb          = res_q.extended_bpb;
	assign fat_kind              = res_q.fat_kind;
	assign sector_total          = res_q.sector_total;
	assign root_dir_sector_count = res_q.root_dir_sector_count;
	assign data_start_sector     = res_q.data_start_sector;
	assign cluster_total         = res_q.cluster_total;
	assign geometry_match        = res_q.geometry_match;

endmodule

// ===== rtl/fbsc_checker.sv =====
// ----------------------------------------------------------------------------
// fbsc_checker
// port-level assertions on the result beats of the boot sector checker
// ----------------------------------------------------------------------------
`include "fat_boot_sector_checker_unit_defines.svh"

module fbsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        status,
	input logic        overall_valid,
	input logic        signature_ok,
	input logic        jump_ok,
	input logic        bpb_ok,
	input logic        extended_bpb,
	input logic [1:0]  fat_kind,
	input logic [31:0] sector_total,
	input logic [20:0] root_dir_sector_count,
	input logic [21:0] data_start_sector,
	input logic [31:0] cluster_total,
	input logic [3:0]  geometry_match
);

	// a stalled result beat holds
	`FBSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(sector_total) && $stable(cluster_total) && $stable(geometry_match))

	// a short buffer reports nothing else
	`FBSC_ASSERT_IMPL(a_short_zero, out_valid && status, !overall_valid && !signature_ok && !jump_ok && !bpb_ok && !extended_bpb && fat_kind == 2'd0 && sector_total == 32'd0 && cluster_total == 32'd0 && geometry_match == 4'd0)

	// fat kind is computed exactly when the BPB passes
	`FBSC_ASSERT_IMPL(a_kind_bpb, out_valid && !status, bpb_ok == (fat_kind != 2'd0))

	// overall validity needs signature and BPB
	`FBSC_ASSERT_IMPL(a_valid_parts, out_valid && overall_valid, signature_ok && bpb_ok)

	// derived counts are zero for a failing BPB
	`FBSC_ASSERT_IMPL(a_bad_bpb_zero, out_valid && !bpb_ok, root_dir_sector_count == 21'd0 && data_start_sector == 22'd0 && cluster_total == 32'd0)

endmodule

bind fat_boot_sector_checker_unit fbsc_checker u_fbsc_checker (.*);
